@@ rtl/ica_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ica_pkg
// Shared widths, operator codes, status codes and item types of the calculator
// ----------------------------------------------------------------------------
package ica_pkg;

	localparam int unsigned DATA_WIDTH  = 32;
	localparam int unsigned CMD_WIDTH   = 8;
	localparam int unsigned ST_WIDTH    = 2;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

	// ascii operator bytes
	localparam logic [CMD_WIDTH-1:0] OP_ADD = 8'd43;
	localparam logic [CMD_WIDTH-1:0] OP_SUB = 8'd45;
	localparam logic [CMD_WIDTH-1:0] OP_MUL = 8'd42;
	localparam logic [CMD_WIDTH-1:0] OP_DIV = 8'd47;
	localparam logic [CMD_WIDTH-1:0] OP_MOD = 8'd37;

	// result status codes
	localparam logic [ST_WIDTH-1:0] ST_OK      = 2'd0;
	localparam logic [ST_WIDTH-1:0] ST_DIVZERO = 2'd1;
	localparam logic [ST_WIDTH-1:0] ST_UNKNOWN = 2'd2;

	typedef enum logic [2:0] {
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV,
		K_MOD,
		K_BAD
	} kind_t;

	// classified operation as it waits in the queue
	typedef struct packed {
		kind_t                 kind;
		logic                  na;
		logic                  nb;
		logic                  dz;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
		logic [DATA_WIDTH-1:0] ua;
		logic [DATA_WIDTH-1:0] ub;
	} item_t;

endpackage
`default_nettype wire

@@ rtl/ica_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ica_if
// Request and response channels of the calculator, valid/ready handshake
// ----------------------------------------------------------------------------
interface ica_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [ica_pkg::CMD_WIDTH-1:0]        command;
	logic signed [ica_pkg::DATA_WIDTH-1:0] left_operand;
	logic signed [ica_pkg::DATA_WIDTH-1:0] right_operand;

	modport source (output valid, command, left_operand, right_operand, input ready);
	modport sink   (input valid, command, left_operand, right_operand, output ready);
endinterface

interface ica_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ica_pkg::DATA_WIDTH-1:0] result_value;
	logic [ica_pkg::ST_WIDTH-1:0]         status;

	modport source (output valid, result_value, status, input ready);
	modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

@@ rtl/ica_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ica_front
// Accepts request beats, decodes the operator and prepares signs and magnitudes
// ----------------------------------------------------------------------------
module ica_front (
	ica_req_if.sink            req,
	output logic               wr_valid,
	input  logic               wr_ready,
	output ica_pkg::item_t     wr_item
);

	logic [ica_pkg::DATA_WIDTH-1:0] a;
	logic [ica_pkg::DATA_WIDTH-1:0] b;

	assign a = req.left_operand;
	assign b = req.right_operand;

	// handshake passes straight to the queue
	assign wr_valid  = req.valid;
	assign req.ready = wr_ready;

	// operator decode and operand preparation
	always_comb begin
		wr_item.a  = a;
		wr_item.b  = b;
		wr_item.na = a[ica_pkg::DATA_WIDTH-1];
		wr_item.nb = b[ica_pkg::DATA_WIDTH-1];
		wr_item.ua = a[ica_pkg::DATA_WIDTH-1] ? (~a + 1'b1) : a;
		wr_item.ub = b[ica_pkg::DATA_WIDTH-1] ? (~b + 1'b1) : b;
		wr_item.dz = (b == '0);
		unique case (req.command)
			ica_pkg::OP_ADD: wr_item.kind = ica_pkg::K_ADD;
			ica_pkg::OP_SUB: wr_item.kind = ica_pkg::K_SUB;
			ica_pkg::OP_MUL: wr_item.kind = ica_pkg::K_MUL;
			ica_pkg::OP_DIV: wr_item.kind = ica_pkg::K_DIV;
			ica_pkg::OP_MOD: wr_item.kind = ica_pkg::K_MOD;
			default:         wr_item.kind = ica_pkg::K_BAD;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/ica_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ica_queue
// Short register queue between decode and execute
// ----------------------------------------------------------------------------
module ica_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  ica_pkg::item_t wr_item,
	output logic           rd_valid,
	input  logic           rd_ready,
	output ica_pkg::item_t rd_item
);

	ica_pkg::item_t                 mem_q [ica_pkg::QUEUE_DEPTH];
	logic [ica_pkg::QPTR_WIDTH-1:0] wr_ptr_q;
	logic [ica_pkg::QPTR_WIDTH-1:0] rd_ptr_q;
	logic [ica_pkg::QCNT_WIDTH-1:0] cnt_q;
	logic                           do_wr;
	logic                           do_rd;

	assign wr_ready = (cnt_q != ica_pkg::QCNT_WIDTH'(ica_pkg::QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == ica_pkg::QPTR_WIDTH'(ica_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == ica_pkg::QPTR_WIDTH'(ica_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// fill count never passes the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ica_pkg::QCNT_WIDTH'(ica_pkg::QUEUE_DEPTH))
		else $error("queue fill count out of range");

endmodule
`default_nettype wire

@@ rtl/ica_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ica_back
// Execute pipeline: add/sub/mul in the first stage, one quotient bit per
// divide stage, sign fix and status in the output register
// ----------------------------------------------------------------------------
module ica_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_valid,
	output logic           rd_ready,
	input  ica_pkg::item_t rd_item,
	ica_rsp_if.source      rsp
);

	localparam int unsigned W = ica_pkg::DATA_WIDTH;

	typedef struct packed {
		ica_pkg::kind_t kind;
		logic           na;
		logic           nb;
		logic           dz;
		logic [W-1:0]   ub;
		logic [W-1:0]   rem;
		logic [W-1:0]   qa;
		logic [W-1:0]   res;
	} stg_t;

	logic             adv;
	logic             v_s1;
	stg_t             stg_s1;
	stg_t             ld;
	logic             v_s2  [W];
	stg_t             stg_s2 [W];
	stg_t             nxt   [W];
	logic             v_s3;
	logic [W-1:0]     res_s3;
	logic [ica_pkg::ST_WIDTH-1:0] st_s3;
	logic [W-1:0]     fin_res;
	logic [ica_pkg::ST_WIDTH-1:0] fin_st;
	stg_t             last;

	// whole pipeline moves unless the output beat is stalled
	assign adv      = !v_s3 || rsp.ready;
	assign rd_ready = adv;

	// first stage: short operations and divider load
	always_comb begin
		ld.kind = rd_item.kind;
		ld.na   = rd_item.na;
		ld.nb   = rd_item.nb;
		ld.dz   = rd_item.dz;
		ld.ub   = rd_item.ub;
		ld.rem  = '0;
		ld.qa   = rd_item.ua;
		unique case (rd_item.kind)
			ica_pkg::K_ADD: ld.res = rd_item.a + rd_item.b;
			ica_pkg::K_SUB: ld.res = rd_item.a - rd_item.b;
			ica_pkg::K_MUL: ld.res = rd_item.a * rd_item.b;
			default:        ld.res = '0;
		endcase
	end

	// restoring divide step per stage
	always_comb begin
		stg_t         src;
		logic [W:0]   t;
		logic         ge;
		for (int k = 0; k < W; k++) begin
			src      = (k == 0) ? stg_s1 : stg_s2[(k == 0) ? 0 : k - 1];
			t        = {src.rem, src.qa[W-1]};
			ge       = (t >= {1'b0, src.ub});
			nxt[k]   = src;
			nxt[k].rem = ge ? W'(t - {1'b0, src.ub}) : t[W-1:0];
			nxt[k].qa  = {src.qa[W-2:0], ge};
		end
	end

	// output stage: sign fix, special cases, status
	assign last = stg_s2[W-1];

	always_comb begin
		unique case (last.kind)
			ica_pkg::K_ADD, ica_pkg::K_SUB, ica_pkg::K_MUL: begin
				fin_res = last.res;
				fin_st  = ica_pkg::ST_OK;
			end
			ica_pkg::K_DIV: begin
				fin_res = last.dz ? '0 : ((last.na ^ last.nb) ? (~last.qa + 1'b1) : last.qa);
				fin_st  = last.dz ? ica_pkg::ST_DIVZERO : ica_pkg::ST_OK;
			end
			ica_pkg::K_MOD: begin
				fin_res = last.dz ? '0 : (last.na ? (~last.rem + 1'b1) : last.rem);
				fin_st  = last.dz ? ica_pkg::ST_DIVZERO : ica_pkg::ST_OK;
			end
			default: begin
				fin_res = '0;
				fin_st  = ica_pkg::ST_UNKNOWN;
			end
		endcase
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s1 <= ld;
			for (int k = 0; k < W; k++) begin
				stg_s2[k] <= nxt[k];
			end
			res_s3 <= fin_res;
			st_s3  <= fin_st;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < W; k++) begin
				v_s2[k] <= 1'b0;
			end
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= rd_valid;
			v_s2[0] <= v_s1;
			for (int k = 1; k < W; k++) begin
				v_s2[k] <= v_s2[k-1];
			end
			v_s3 <= v_s2[W-1];
		end
	end

	assign rsp.valid        = v_s3;
	assign rsp.result_value = res_s3;
	assign rsp.status       = st_s3;

	// a taken queue beat enters the first stage
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid && rd_ready |=> v_s1)
		else $error("accepted beat lost at execute entry");

	// any error status carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (st_s3 != ica_pkg::ST_OK) |-> (res_s3 == '0))
		else $error("error status with nonzero result");

	// status code stays in range
	a_st_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (st_s3 == ica_pkg::ST_OK || st_s3 == ica_pkg::ST_DIVZERO ||
			st_s3 == ica_pkg::ST_UNKNOWN))
		else $error("status code out of range");

endmodule
`default_nettype wire

@@ rtl/integer_calculator_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_calculator_alu
// Signed 32-bit add, subtract, multiply, truncating divide and remainder
// ----------------------------------------------------------------------------
//  channel  dir  payload                                      handshake
//  req      in   command, left_operand, right_operand         valid/ready
//  rsp      out  result_value, status                         valid/ready
//
//  one operation per cycle sustained while responses are taken; every
//  operation passes in order through the one-bit-per-stage divide
//  pipeline on its way from request beat to response beat
//  reset clears valid bits, queue pointers and queue fill count only
//  a stalled response holds the execute pipeline; the two-entry queue keeps
//  taking request beats until it fills
// ----------------------------------------------------------------------------
module integer_calculator_alu (
	input  logic      clk,
	input  logic      arst_n,
	ica_req_if.sink   req,
	ica_rsp_if.source rsp
);

	logic           fq_valid;
	logic           fq_ready;
	ica_pkg::item_t fq_item;
	logic           qb_valid;
	logic           qb_ready;
	ica_pkg::item_t qb_item;

	// decode
	ica_front u_front (
		.req      (req),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_item  (fq_item)
	);

	// decoupling queue
	ica_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_item  (fq_item),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_item  (qb_item)
	);

	// execute
	ica_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_item  (qb_item),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
